/* design/csrmv_pkg.sv */
// Shared types and constants for the CSR sparse matrix-vector multiplier.
`default_nettype none

package csrmv_pkg;

    // Field widths of the channels, the configuration registers and the accumulator.
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int ROW_W     = 16;
    localparam int COLS_W    = 11;
    localparam int ROWS_W    = 17;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    // Vector index widened so that it can address any supported store depth.
    localparam int ADDR_EXT_W = 17;

    // Default store depth and queue depth between front and back.
    localparam int VEC_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH   = 4;

    // Configuration register reset values.
    localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 17'd65536;

    // Operation codes of a request.
    localparam logic [1:0] OP_VEC_WRITE = 2'd0;
    localparam logic [1:0] OP_NONZERO   = 2'd1;
    localparam logic [1:0] OP_CLOSE     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic                      term;    // product goes into the sum
        logic                      bad;     // column index out of range
        logic                      closes;  // this request ends the row
        logic signed [VALUE_W-1:0] value;   // matrix nonzero
        logic signed [VALUE_W-1:0] xval;    // vector entry for its column
    } t_entry;

endpackage

`default_nettype wire

/* design/csr_sparse_matrix_vector_multiply.sv */
// Top level of the CSR sparse matrix-vector multiplier.
//
// Computes y = A*x in Q16.16. Write x first with vector-write requests, then stream the
// nonzeros of A in row order; each request closing a row (last_in_row, or an empty-row
// close) yields one result with the row number, the floored and saturated row sum and
// flags. The block takes one request per cycle when not stalled: the front stage reads
// the vector store, a four-entry queue follows, then one 32x32 multiply stage and one
// 64-bit saturating accumulate per cycle. A closing request passes the front stage,
// queue, multiply stage, closed-row stage and output register. No clearing pass is
// needed after reset; vector entries must be written before they are used.
// Configuration must be written only while the block is idle; it is not enforced.
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
    parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // Configuration writes.
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [csrmv_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [csrmv_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Request channel.
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic [1:0]                              i_operation,
    input  wire logic [csrmv_pkg::INDEX_W-1:0]           i_index,
    input  wire logic signed [csrmv_pkg::VALUE_W-1:0]    i_element_value,
    input  wire logic                                    i_last_in_row,
    // Result channel.
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic      [csrmv_pkg::ROW_W-1:0]             o_row_number,
    output logic signed [csrmv_pkg::VALUE_W-1:0]         o_row_sum,
    output logic                                         o_sum_saturated,
    output logic                                         o_bad_column
);

    localparam int EW = $bits(csrmv_pkg::t_entry);

    logic [csrmv_pkg::COLS_W-1:0] r_cols_in_use;
    logic [csrmv_pkg::ROWS_W-1:0] r_rows_in_use;

    csrmv_pkg::t_entry w_push_entry;
    csrmv_pkg::t_entry w_pop_entry;
    logic [EW-1:0]     w_pop_bits;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_in_use <= csrmv_pkg::COLS_RESET;
            r_rows_in_use <= csrmv_pkg::ROWS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csrmv_pkg::CFG_COLS: r_cols_in_use <= i_cfg_data[csrmv_pkg::COLS_W-1:0];
                csrmv_pkg::CFG_ROWS: r_rows_in_use <= i_cfg_data[csrmv_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    csrmv_front #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cols_in_use   (r_cols_in_use),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_index         (i_index),
        .i_element_value (i_element_value),
        .i_last_in_row   (i_last_in_row),
        .o_push          (w_push),
        .o_entry         (w_push_entry),
        .i_queue_full    (w_full)
    );

    csrmv_queue #(
        .WIDTH (EW),
        .DEPTH (csrmv_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_bits)
    );

    assign w_pop_entry = csrmv_pkg::t_entry'(w_pop_bits);

    csrmv_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rows_in_use   (r_rows_in_use),
        .i_entry         (w_pop_entry),
        .i_queue_empty   (w_empty),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_row_number    (o_row_number),
        .o_row_sum       (o_row_sum),
        .o_sum_saturated (o_sum_saturated),
        .o_bad_column    (o_bad_column)
    );

endmodule

`default_nettype wire

/* design/csrmv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/csrmv_queue.sv */
// Small first-in first-out queue that decouples the front from the back.
`default_nettype none

module csrmv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/csrmv_front.sv */
// Front end: accepts requests, writes the vector store and classifies nonzeros.
`default_nettype none

module csrmv_front #(
    parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [csrmv_pkg::COLS_W-1:0]         i_cols_in_use,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_operation,
    input  wire logic [csrmv_pkg::INDEX_W-1:0]        i_index,
    input  wire logic signed [csrmv_pkg::VALUE_W-1:0] i_element_value,
    input  wire logic                                 i_last_in_row,
    output logic                                      o_push,
    output csrmv_pkg::t_entry                         o_entry,
    input  wire logic                                 i_queue_full
);

    localparam int AW    = $clog2(VEC_DEPTH);
    localparam int EXT_W = csrmv_pkg::ADDR_EXT_W;
    localparam int VW    = csrmv_pkg::VALUE_W;

    logic             w_accept;
    logic             w_is_vec;
    logic             w_is_nz;
    logic             w_is_close;
    logic [EXT_W-1:0] w_idx_ext;
    logic             w_in_store;
    logic             w_col_bad;
    logic [AW-1:0]    w_addr;
    logic [VW-1:0]    w_rdata;

    logic                 r_s_valid, n_s_valid;
    logic                 r_s_term;
    logic                 r_s_bad;
    logic                 r_s_closes;
    logic signed [VW-1:0] r_s_value;

    // The stage register frees up whenever its request moves into the queue.
    assign o_push     = r_s_valid && !i_queue_full;
    assign o_in_ready = !r_s_valid || !i_queue_full;
    assign w_accept   = i_in_valid && o_in_ready;

    // Operation decoder.
    always_comb begin
        w_is_vec   = 1'b0;
        w_is_nz    = 1'b0;
        w_is_close = 1'b0;
        unique case (i_operation)
            csrmv_pkg::OP_VEC_WRITE: w_is_vec   = 1'b1;
            csrmv_pkg::OP_NONZERO:   w_is_nz    = 1'b1;
            csrmv_pkg::OP_CLOSE:     w_is_close = 1'b1;
            default: ;
        endcase
    end

    // Range checks against the store depth and the columns in use.
    assign w_idx_ext  = EXT_W'(i_index);
    assign w_in_store = (32'(w_idx_ext) < 32'(VEC_DEPTH));
    assign w_col_bad  = !w_in_store || (EXT_W'(i_index) >= EXT_W'(i_cols_in_use));
    assign w_addr     = w_idx_ext[AW-1:0];

    // Vector store: writes from vector requests, reads for each nonzero.
    csrmv_ram #(
        .WIDTH (VW),
        .DEPTH (VEC_DEPTH)
    ) u_vec_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_is_vec && w_in_store),
        .i_waddr (w_addr),
        .i_wdata (i_element_value),
        .i_re    (w_accept && w_is_nz),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Stage register valid.
    always_comb begin
        n_s_valid = r_s_valid;
        if (w_accept && (w_is_nz || w_is_close)) begin
            n_s_valid = 1'b1;
        end else if (o_push) begin
            n_s_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= n_s_valid;
        end
    end

    // Stage payload: classification of the accepted nonzero or close request.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_is_nz || w_is_close)) begin
            r_s_term   <= w_is_nz && !w_col_bad;
            r_s_bad    <= w_is_nz && w_col_bad;
            r_s_closes <= w_is_close || i_last_in_row;
            r_s_value  <= i_element_value;
        end
    end

    // Queue entry combines the stage register with the store read data.
    always_comb begin
        o_entry.term   = r_s_term;
        o_entry.bad    = r_s_bad;
        o_entry.closes = r_s_closes;
        o_entry.value  = r_s_value;
        o_entry.xval   = w_rdata;
    end

endmodule

`default_nettype wire

/* design/csrmv_back.sv */
// Back end: multiplies, accumulates per row and delivers saturated row sums.
`default_nettype none

module csrmv_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [csrmv_pkg::ROWS_W-1:0]          i_rows_in_use,
    input  wire csrmv_pkg::t_entry                     i_entry,
    input  wire logic                                  i_queue_empty,
    output logic                                       o_pop,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic      [csrmv_pkg::ROW_W-1:0]           o_row_number,
    output logic signed [csrmv_pkg::VALUE_W-1:0]       o_row_sum,
    output logic                                       o_sum_saturated,
    output logic                                       o_bad_column
);

    localparam int AW  = csrmv_pkg::ACC_W;
    localparam int RW  = csrmv_pkg::ROW_W;
    localparam int QW  = csrmv_pkg::ROWS_W;
    localparam int VW  = csrmv_pkg::VALUE_W;
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // Saturating signed add of two accumulator-width values.
    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] b
    );
        logic signed [AW-1:0] s;
        s = a + b;
        if ((a[AW-1] == b[AW-1]) && (s[AW-1] != a[AW-1])) begin
            return a[AW-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    // Multiply stage.
    logic                 r_m_valid, n_m_valid;
    logic                 r_m_term;
    logic                 r_m_bad;
    logic                 r_m_closes;
    logic signed [AW-1:0] r_m_prod;

    // Row state.
    logic signed [AW-1:0] r_acc, n_acc;
    logic                 r_row_bad, n_row_bad;
    logic [RW-1:0]        r_row, n_row;

    // Closed-row stage.
    logic                 r_c_valid, n_c_valid;
    logic signed [AW-1:0] r_c_acc;
    logic                 r_c_bad;
    logic [RW-1:0]        r_c_row;

    // Output register.
    logic r_out_valid, n_out_valid;

    logic                 w_out_free;
    logic                 w_c_adv;
    logic                 w_c_free;
    logic                 w_m_adv;
    logic                 w_m_free;
    logic                 w_close;
    logic signed [AW-1:0] w_sum;
    logic                 w_bad;
    logic [QW-1:0]        w_row_inc;
    logic [RW-1:0]        w_row_next;
    logic                 w_pos_sat;
    logic                 w_neg_sat;

    // Backpressure chain from the output register back to the queue.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_c_adv    = r_c_valid && w_out_free;
    assign w_c_free   = !r_c_valid || w_c_adv;
    assign w_m_adv    = r_m_valid && (!r_m_closes || w_c_free);
    assign w_m_free   = !r_m_valid || w_m_adv;
    assign o_pop      = !i_queue_empty && w_m_free;
    assign w_close    = w_m_adv && r_m_closes;

    // Multiply stage valid.
    always_comb begin
        n_m_valid = r_m_valid;
        if (o_pop) begin
            n_m_valid = 1'b1;
        end else if (w_m_adv) begin
            n_m_valid = 1'b0;
        end
    end

    // Multiply stage payload: one exact Q32.32 product per nonzero.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_term   <= i_entry.term;
            r_m_bad    <= i_entry.bad;
            r_m_closes <= i_entry.closes;
            r_m_prod   <= AW'(i_entry.value) * AW'(i_entry.xval);
        end
    end

    // Accumulate step and row counter advance.
    always_comb begin
        w_sum      = r_m_term ? sat_add(r_acc, r_m_prod) : r_acc;
        w_bad      = r_row_bad || r_m_bad;
        w_row_inc  = QW'(r_row) + QW'(1);
        w_row_next = (w_row_inc >= i_rows_in_use) ? '0 : w_row_inc[RW-1:0];

        n_acc     = r_acc;
        n_row_bad = r_row_bad;
        n_row     = r_row;
        if (w_close) begin
            n_acc     = '0;
            n_row_bad = 1'b0;
            n_row     = w_row_next;
        end else if (w_m_adv) begin
            n_acc     = w_sum;
            n_row_bad = w_bad;
        end
    end

    // Closed-row stage valid.
    always_comb begin
        n_c_valid = r_c_valid;
        if (w_close) begin
            n_c_valid = 1'b1;
        end else if (w_c_adv) begin
            n_c_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_c_acc <= w_sum;
            r_c_bad <= w_bad;
            r_c_row <= r_row;
        end
    end

    // Conversion to Q16.16: floor by dropping the low bits, then clip.
    assign w_pos_sat = !r_c_acc[AW-1] && (|r_c_acc[AW-2:47]);
    assign w_neg_sat = r_c_acc[AW-1] && !(&r_c_acc[AW-2:47]);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_c_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_adv) begin
            o_row_number    <= r_c_row;
            o_sum_saturated <= w_pos_sat || w_neg_sat;
            o_bad_column    <= r_c_bad;
            if (w_pos_sat) begin
                o_row_sum <= {1'b0, {(VW-1){1'b1}}};
            end else if (w_neg_sat) begin
                o_row_sum <= {1'b1, {(VW-1){1'b0}}};
            end else begin
                o_row_sum <= r_c_acc[47:16];
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_row_bad   <= 1'b0;
            r_row       <= '0;
        end else begin
            r_m_valid   <= n_m_valid;
            r_c_valid   <= n_c_valid;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_row_bad   <= n_row_bad;
            r_row       <= n_row;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
